/* rtl/reservation_station_issue_table_assert.svh */
// assertion macros used by rtl/rsit_datapath.sv
`ifndef RESERVATION_STATION_ISSUE_TABLE_ASSERT_SVH
`define RESERVATION_STATION_ISSUE_TABLE_ASSERT_SVH
// same-cycle implication
`define RSIT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define RSIT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);
`endif

/* rtl/rsit_pkg.sv */
// types, codes and defaults of the reservation station table
package rsit_pkg;
   localparam int DEF_NUM_REGS       = 32;
   localparam int DEF_LOAD_STATIONS  = 2;
   localparam int DEF_ADD_STATIONS   = 3;
   localparam int DEF_MUL_STATIONS   = 2;
   localparam int DEF_STORE_STATIONS = 2;
   localparam int DEF_MAX_DISPATCH   = 3;

   localparam logic [1:0] OP_ISSUE = 2'd0;
   localparam logic [1:0] OP_BCAST = 2'd1;
   localparam logic [1:0] OP_DISP  = 2'd2;

   localparam logic [2:0] KIND_LOAD  = 3'd0;
   localparam logic [2:0] KIND_STORE = 3'd1;
   localparam logic [2:0] KIND_ADD   = 3'd2;
   localparam logic [2:0] KIND_SUB   = 3'd3;
   localparam logic [2:0] KIND_MUL   = 3'd4;

   typedef struct packed {
      logic [1:0]         operation;
      logic [2:0]         op_kind;
      logic [4:0]         dest_reg;
      logic [4:0]         src1_reg;
      logic [4:0]         src2_reg;
      logic [63:0]        src1_value;
      logic [63:0]        src2_value;
      logic signed [31:0] offset;
      logic [15:0]        instr_id;
      logic [3:0]         bcast_tag;
      logic [63:0]        bcast_value;
   } req_type;

   typedef struct packed {
      logic        accepted;
      logic [3:0]  station;
      logic [2:0]  station_op;
      logic [63:0] operand_j;
      logic [63:0] operand_k;
      logic [15:0] station_instr;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic do_issue;
      logic do_bcast;
      logic do_step;
   } cmd_type;

   typedef struct packed {
      logic last;
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_BCAST,
      ST_DISP
   } state_type;
endpackage

/* rtl/rsit_ctrl.sv */
// controller state machine sequencing issue, broadcast and dispatch
module rsit_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [1:0]          operation,
   input  rsit_pkg::status_type status,
   output logic                busy,
   output rsit_pkg::cmd_type   cmd
);
   import rsit_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.capture = 1'b1;
               unique case (operation)
                  OP_ISSUE: state_in = ST_ISSUE;
                  OP_BCAST: state_in = ST_BCAST;
                  OP_DISP:  state_in = ST_DISP;
                  default:  state_in = ST_IDLE;
               endcase
            end
         end
         ST_ISSUE: begin
            cmd.do_issue = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_BCAST: begin
            cmd.do_bcast = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_DISP: begin
            cmd.do_step = 1'b1;
            if (status.last) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule

/* rtl/rsit_datapath.sv */
// station entries, producer match, issue/broadcast update and dispatch scan
module rsit_datapath #(
   parameter int NUM_REGS       = rsit_pkg::DEF_NUM_REGS,
   parameter int LOAD_STATIONS  = rsit_pkg::DEF_LOAD_STATIONS,
   parameter int ADD_STATIONS   = rsit_pkg::DEF_ADD_STATIONS,
   parameter int MUL_STATIONS   = rsit_pkg::DEF_MUL_STATIONS,
   parameter int STORE_STATIONS = rsit_pkg::DEF_STORE_STATIONS,
   parameter int MAX_DISPATCH   = rsit_pkg::DEF_MAX_DISPATCH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  rsit_pkg::req_type    req,
   input  rsit_pkg::cmd_type    cmd,
   output rsit_pkg::status_type status,
   output logic                 rsp_valid,
   output rsit_pkg::rsp_type    rsp
);
   import rsit_pkg::*;
`include "reservation_station_issue_table_assert.svh"

   localparam int NST        = LOAD_STATIONS + ADD_STATIONS + MUL_STATIONS + STORE_STATIONS;
   localparam int STA_W      = $clog2(NST);
   localparam int TAG_W      = $clog2(NST + 1);
   localparam int CNT_W      = $clog2(MAX_DISPATCH + 1);
   localparam int BASE_LOAD  = 0;
   localparam int BASE_ADD   = LOAD_STATIONS;
   localparam int BASE_MUL   = LOAD_STATIONS + ADD_STATIONS;
   localparam int BASE_STORE = LOAD_STATIONS + ADD_STATIONS + MUL_STATIONS;

   req_type req_ff;

   logic              busy_ff [NST], busy_in [NST];
   logic [2:0]        kind_ff [NST], kind_in [NST];
   logic [63:0]       vj_ff   [NST], vj_in   [NST];
   logic [63:0]       vk_ff   [NST], vk_in   [NST];
   logic [TAG_W-1:0]  qj_ff   [NST], qj_in   [NST];
   logic [TAG_W-1:0]  qk_ff   [NST], qk_in   [NST];
   logic [15:0]       seq_ff  [NST], seq_in  [NST];
   logic [4:0]        dst_ff  [NST], dst_in  [NST];
   logic              prod_ff [NST], prod_in [NST];
   logic              sent_ff [NST], sent_in [NST];
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   // producer lookup by associative match on station destinations
   function automatic logic [TAG_W-1:0] producer_of(input logic [4:0] r,
                                                    input logic pr [NST],
                                                    input logic [4:0] ds [NST]);
      logic [TAG_W-1:0] p;
      p = '0;
      for (int i = 0; i < NST; i++)
         if (pr[i] && ds[i] == r) p = TAG_W'(i + 1);
      return p;
   endfunction

   logic              cls_found;
   logic [STA_W-1:0]  cls_sel;
   int                cls_base, cls_cnt;
   logic              iss_ok;
   logic [TAG_W-1:0]  p_dst, p_s1, p_s2;
   logic [63:0]       off_ext;
   logic [63:0]       n_vj, n_vk;
   logic [TAG_W-1:0]  n_qj, n_qk;
   logic [TAG_W-1:0]  btag;
   logic              bvalid;
   logic              rdy [NST];
   logic              pick_found, more;
   logic [STA_W-1:0]  pick;

   always_comb begin
      p_dst   = producer_of(req_ff.dest_reg, prod_ff, dst_ff);
      p_s1    = producer_of(req_ff.src1_reg, prod_ff, dst_ff);
      p_s2    = producer_of(req_ff.src2_reg, prod_ff, dst_ff);
      off_ext = 64'(req_ff.offset);

      // class range of the issued kind
      cls_base = BASE_ADD;
      cls_cnt  = ADD_STATIONS;
      unique case (req_ff.op_kind)
         KIND_LOAD:  begin cls_base = BASE_LOAD;  cls_cnt = LOAD_STATIONS;  end
         KIND_STORE: begin cls_base = BASE_STORE; cls_cnt = STORE_STATIONS; end
         KIND_MUL:   begin cls_base = BASE_MUL;   cls_cnt = MUL_STATIONS;   end
         default:    begin cls_base = BASE_ADD;   cls_cnt = ADD_STATIONS;   end
      endcase
      cls_found = 1'b0;
      cls_sel   = '0;
      for (int i = 0; i < NST; i++)
         if (!cls_found && i >= cls_base && i < cls_base + cls_cnt && !busy_ff[i]) begin
            cls_found = 1'b1;
            cls_sel   = STA_W'(i);
         end

      iss_ok = 1'b0;
      n_vj   = '0;
      n_vk   = '0;
      n_qj   = '0;
      n_qk   = '0;
      unique case (req_ff.op_kind)
         KIND_LOAD: begin
            iss_ok = cls_found && p_dst == '0;
            n_vj   = off_ext;
            n_vk   = req_ff.src1_value;
         end
         KIND_STORE: begin
            iss_ok = cls_found;
            n_vj   = off_ext + req_ff.src1_value;
            n_qk   = p_dst;
            n_vk   = (p_dst != '0) ? 64'd0 : req_ff.src2_value;
         end
         KIND_ADD, KIND_SUB, KIND_MUL: begin
            iss_ok = cls_found && p_dst == '0;
            n_qj   = p_s1;
            n_vj   = (p_s1 != '0) ? 64'd0 : req_ff.src1_value;
            n_qk   = p_s2;
            n_vk   = (p_s2 != '0) ? 64'd0 : req_ff.src2_value;
         end
         default: iss_ok = 1'b0;
      endcase

      bvalid = 5'(req_ff.bcast_tag) < 5'(NST);
      btag   = TAG_W'(5'(req_ff.bcast_tag) + 5'd1);

      // dispatch scan: lowest ready station not yet reported
      pick_found = 1'b0;
      pick       = '0;
      more       = 1'b0;
      for (int i = 0; i < NST; i++) begin
         rdy[i] = busy_ff[i] && qj_ff[i] == '0 && qk_ff[i] == '0 && !sent_ff[i];
         if (rdy[i] && pick_found) more = 1'b1;
         if (rdy[i] && !pick_found) begin
            pick_found = 1'b1;
            pick       = STA_W'(i);
         end
      end
      status.last = !pick_found || !more || cnt_ff == CNT_W'(MAX_DISPATCH - 1);
   end

   always_comb begin
      busy_in = busy_ff;
      kind_in = kind_ff;
      vj_in   = vj_ff;
      vk_in   = vk_ff;
      qj_in   = qj_ff;
      qk_in   = qk_ff;
      seq_in  = seq_ff;
      dst_in  = dst_ff;
      prod_in = prod_ff;
      sent_in = sent_ff;
      cnt_in  = cnt_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;

      if (cmd.capture) begin
         for (int i = 0; i < NST; i++) sent_in[i] = 1'b0;
         cnt_in = '0;
      end

      if (cmd.do_issue) begin
         rsp_valid_in = 1'b1;
         rsp_in.last  = 1'b1;
         if (iss_ok) begin
            busy_in[cls_sel] = 1'b1;
            kind_in[cls_sel] = req_ff.op_kind;
            vj_in[cls_sel]   = n_vj;
            vk_in[cls_sel]   = n_vk;
            qj_in[cls_sel]   = n_qj;
            qk_in[cls_sel]   = n_qk;
            seq_in[cls_sel]  = req_ff.instr_id;
            dst_in[cls_sel]  = req_ff.dest_reg;
            prod_in[cls_sel] = req_ff.op_kind != KIND_STORE
                               && 7'(req_ff.dest_reg) < 7'(NUM_REGS);
            rsp_in.accepted      = 1'b1;
            rsp_in.station       = 4'(cls_sel);
            rsp_in.station_op    = req_ff.op_kind;
            rsp_in.operand_j     = n_vj;
            rsp_in.operand_k     = n_vk;
            rsp_in.station_instr = req_ff.instr_id;
         end
      end

      if (cmd.do_bcast && bvalid) begin
         for (int i = 0; i < NST; i++) begin
            if (qj_ff[i] == btag) begin
               vj_in[i] = req_ff.bcast_value;
               qj_in[i] = '0;
            end
            if (qk_ff[i] == btag) begin
               vk_in[i] = req_ff.bcast_value;
               qk_in[i] = '0;
            end
            if (5'(i) == 5'(req_ff.bcast_tag)) begin
               busy_in[i] = 1'b0;
               kind_in[i] = '0;
               vj_in[i]   = '0;
               vk_in[i]   = '0;
               qj_in[i]   = '0;
               qk_in[i]   = '0;
               seq_in[i]  = '0;
               prod_in[i] = 1'b0;
            end
         end
      end

      if (cmd.do_step) begin
         rsp_valid_in = 1'b1;
         rsp_in.last  = status.last;
         if (pick_found) begin
            sent_in[pick] = 1'b1;
            cnt_in        = cnt_ff + CNT_W'(1);
            rsp_in.accepted      = 1'b1;
            rsp_in.station       = 4'(pick);
            rsp_in.station_op    = kind_ff[pick];
            rsp_in.operand_j     = vj_ff[pick];
            rsp_in.operand_k     = vk_ff[pick];
            rsp_in.station_instr = seq_ff[pick];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NST; i++) begin
            busy_ff[i] <= 1'b0;
            kind_ff[i] <= '0;
            vj_ff[i]   <= '0;
            vk_ff[i]   <= '0;
            qj_ff[i]   <= '0;
            qk_ff[i]   <= '0;
            seq_ff[i]  <= '0;
            prod_ff[i] <= 1'b0;
            sent_ff[i] <= 1'b0;
         end
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         kind_ff      <= kind_in;
         vj_ff        <= vj_in;
         vk_ff        <= vk_in;
         qj_ff        <= qj_in;
         qk_ff        <= qk_in;
         seq_ff       <= seq_in;
         prod_ff      <= prod_in;
         sent_ff      <= sent_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dst_ff <= dst_in;
      rsp_ff <= rsp_in;
      if (cmd.capture) req_ff <= req;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   `RSIT_NEXT(a_rsp_from_cmd, cmd.do_issue || cmd.do_step, rsp_valid_ff, "missing result item")
   `RSIT_NEXT(a_no_stray_rsp, !cmd.do_issue && !cmd.do_step, !rsp_valid_ff, "stray result item")
   `RSIT_IMPLY(a_cnt_bound, 1'b1, cnt_ff <= CNT_W'(MAX_DISPATCH), "dispatch count overrun")
   `RSIT_IMPLY(a_step_cap, cmd.do_step && cnt_ff == CNT_W'(MAX_DISPATCH - 1), status.last,
               "dispatch past limit")
endmodule

/* rtl/reservation_station_issue_table.sv */
// top level of the reservation station table with register status match
//  channel  | ports                  | handshake
//  request  | start, busy, req       | taken when start high and busy low
//  response | rsp_valid, rsp         | one-cycle strobe, no back pressure
// issue gives a registered result; a broadcast gives no result
// dispatch gives n results (n from 1 to MAX_DISPATCH),
// one result per cycle from the sequential scan of the station entries
// busy is high from accept until the last result is on the ports
// synchronous reset empties all stations; no clearing pass is needed
module reservation_station_issue_table #(
   parameter int NUM_REGS       = rsit_pkg::DEF_NUM_REGS,
   parameter int LOAD_STATIONS  = rsit_pkg::DEF_LOAD_STATIONS,
   parameter int ADD_STATIONS   = rsit_pkg::DEF_ADD_STATIONS,
   parameter int MUL_STATIONS   = rsit_pkg::DEF_MUL_STATIONS,
   parameter int STORE_STATIONS = rsit_pkg::DEF_STORE_STATIONS,
   parameter int MAX_DISPATCH   = rsit_pkg::DEF_MAX_DISPATCH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  rsit_pkg::req_type req,
   output logic              rsp_valid,
   output rsit_pkg::rsp_type rsp
);
   import rsit_pkg::*;

   cmd_type    cmd;
   status_type status;

   rsit_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .operation (req.operation),
      .status    (status),
      .busy      (busy),
      .cmd       (cmd)
   );

   rsit_datapath #(
      .NUM_REGS       (NUM_REGS),
      .LOAD_STATIONS  (LOAD_STATIONS),
      .ADD_STATIONS   (ADD_STATIONS),
      .MUL_STATIONS   (MUL_STATIONS),
      .STORE_STATIONS (STORE_STATIONS),
      .MAX_DISPATCH   (MAX_DISPATCH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );
endmodule
